// ===== hdl/two_class_fifo_oldest_first_macros.svh =====
// Assertion macros used by the checker file of the two-class FIFO.
`ifndef TWO_CLASS_FIFO_OLDEST_FIRST_MACROS_SVH
`define TWO_CLASS_FIFO_OLDEST_FIRST_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TCFO_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tcfo assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TCFO_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tcfo assertion failed");

`endif

// ===== hdl/tcfo_pkg.sv =====
// Constants, codes and types of the two-class FIFO.
package tcfo_pkg;

  localparam int QUEUE_DEPTH = 256;
  localparam int ID_BITS     = 32;
  localparam int STAMP_BITS  = 16;
  localparam int ADDR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS    = ADDR_BITS + 1;
  localparam int ENTRY_BITS  = ID_BITS + STAMP_BITS;

  localparam logic [CNT_BITS-1:0] FULL_COUNT = CNT_BITS'(QUEUE_DEPTH);

  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  localparam logic [1:0] PICK_OLDEST = 2'd0;
  localparam logic [1:0] PICK_POS    = 2'd1;
  localparam logic [1:0] PICK_NEG    = 2'd2;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RD   = 2'b10
  } state_t;

endpackage

// ===== hdl/two_class_fifo_oldest_first.sv =====
// An enqueue writes its queue memory when accepted; a full-queue report is shown the next cycle.
// A dequeue reads both head entries from the queue memories into registers, picks a head
// in the read state and then registers its result; in_stall is high in between.
// One enqueue per cycle while no result is held by out_stall; a dequeue holds off the next request.
// Reset (rst_n, synchronous, active low) empties both queues and clears the stamp counter;
// the queue memories are not cleared.
module two_class_fifo_oldest_first (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_cmd,
  input  logic [1:0]                       in_pick,
  input  logic signed [tcfo_pkg::ID_BITS-1:0] in_ident,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       out_status,
  output logic signed [tcfo_pkg::ID_BITS-1:0] out_ident_out
);

  logic [tcfo_pkg::ENTRY_BITS-1:0] pos_mem [tcfo_pkg::QUEUE_DEPTH];
  logic [tcfo_pkg::ENTRY_BITS-1:0] neg_mem [tcfo_pkg::QUEUE_DEPTH];

  tcfo_pkg::state_t state_r, state_nxt;

  logic [tcfo_pkg::ADDR_BITS-1:0]  pos_head_r, pos_head_nxt;
  logic [tcfo_pkg::ADDR_BITS-1:0]  neg_head_r, neg_head_nxt;
  logic [tcfo_pkg::CNT_BITS-1:0]   pos_count_r, pos_count_nxt;
  logic [tcfo_pkg::CNT_BITS-1:0]   neg_count_r, neg_count_nxt;
  logic [tcfo_pkg::STAMP_BITS-1:0] stamp_r, stamp_nxt;
  logic [1:0]                      pick_r;

  logic [tcfo_pkg::ENTRY_BITS-1:0] pos_rd_r;
  logic [tcfo_pkg::ENTRY_BITS-1:0] neg_rd_r;

  logic                            out_valid_r, out_valid_nxt;
  logic [1:0]                      out_status_r, out_status_nxt;
  logic [tcfo_pkg::ID_BITS-1:0]    out_ident_r, out_ident_nxt;

  logic                            accept;
  logic                            is_neg;
  logic                            pos_wr, neg_wr;
  logic [tcfo_pkg::ADDR_BITS-1:0]  pos_tail, neg_tail;
  logic [tcfo_pkg::ENTRY_BITS-1:0] wr_entry;

  // A request is only taken in the idle state when the output register is free or draining this cycle.
  assign in_stall = (state_r != tcfo_pkg::ST_IDLE) || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;

  assign is_neg   = in_ident[tcfo_pkg::ID_BITS-1];
  assign pos_tail = pos_head_r + pos_count_r[tcfo_pkg::ADDR_BITS-1:0];
  assign neg_tail = neg_head_r + neg_count_r[tcfo_pkg::ADDR_BITS-1:0];
  assign wr_entry = {stamp_r, in_ident};

  assign pos_wr = accept && (in_cmd == tcfo_pkg::CMD_ENQ) && (in_ident != '0) && !is_neg
                  && (pos_count_r != tcfo_pkg::FULL_COUNT);
  assign neg_wr = accept && (in_cmd == tcfo_pkg::CMD_ENQ) && is_neg
                  && (neg_count_r != tcfo_pkg::FULL_COUNT);

  always_ff @(posedge clk) begin
    if (pos_wr) begin
      pos_mem[pos_tail] <= wr_entry;
    end
    pos_rd_r <= pos_mem[pos_head_r];
  end

  always_ff @(posedge clk) begin
    if (neg_wr) begin
      neg_mem[neg_tail] <= wr_entry;
    end
    neg_rd_r <= neg_mem[neg_head_r];
  end

  always_comb begin
    logic                            pos_has, neg_has;
    logic                            take_pos, take_neg;
    logic [tcfo_pkg::STAMP_BITS-1:0] diff;

    state_nxt      = state_r;
    pos_head_nxt   = pos_head_r;
    neg_head_nxt   = neg_head_r;
    pos_count_nxt  = pos_count_r;
    neg_count_nxt  = neg_count_r;
    stamp_nxt      = stamp_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_ident_nxt  = out_ident_r;

    pos_has  = (pos_count_r != '0);
    neg_has  = (neg_count_r != '0);
    diff     = pos_rd_r[tcfo_pkg::ENTRY_BITS-1:tcfo_pkg::ID_BITS]
             - neg_rd_r[tcfo_pkg::ENTRY_BITS-1:tcfo_pkg::ID_BITS];
    take_pos = 1'b0;
    take_neg = 1'b0;

    case (state_r)
      tcfo_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_cmd == tcfo_pkg::CMD_DEQ) begin
            state_nxt = tcfo_pkg::ST_RD;
          end else if (pos_wr) begin
            pos_count_nxt = pos_count_r + 1'b1;
            stamp_nxt     = stamp_r + 1'b1;
          end else if (neg_wr) begin
            neg_count_nxt = neg_count_r + 1'b1;
            stamp_nxt     = stamp_r + 1'b1;
          end else if (in_ident != '0) begin
            // The selected queue is full: the request is dropped and reported.
            out_valid_nxt  = 1'b1;
            out_status_nxt = tcfo_pkg::STATUS_FULL;
            out_ident_nxt  = '0;
          end
        end
      end
      tcfo_pkg::ST_RD: begin
        case (pick_r)
          tcfo_pkg::PICK_POS: take_pos = pos_has;
          tcfo_pkg::PICK_NEG: take_neg = neg_has;
          tcfo_pkg::PICK_OLDEST: begin
            // With both queues occupied, the positive head wins only if its stamp is older.
            if (pos_has && neg_has) begin
              take_pos = diff[tcfo_pkg::STAMP_BITS-1];
              take_neg = !diff[tcfo_pkg::STAMP_BITS-1];
            end else begin
              take_pos = pos_has;
              take_neg = neg_has;
            end
          end
          default: begin
            take_pos = 1'b0;
            take_neg = 1'b0;
          end
        endcase
        out_valid_nxt = 1'b1;
        if (take_pos) begin
          out_status_nxt = tcfo_pkg::STATUS_OK;
          out_ident_nxt  = pos_rd_r[tcfo_pkg::ID_BITS-1:0];
          pos_head_nxt   = pos_head_r + 1'b1;
          pos_count_nxt  = pos_count_r - 1'b1;
        end else if (take_neg) begin
          out_status_nxt = tcfo_pkg::STATUS_OK;
          out_ident_nxt  = neg_rd_r[tcfo_pkg::ID_BITS-1:0];
          neg_head_nxt   = neg_head_r + 1'b1;
          neg_count_nxt  = neg_count_r - 1'b1;
        end else begin
          out_status_nxt = tcfo_pkg::STATUS_EMPTY;
          out_ident_nxt  = '0;
        end
        state_nxt = tcfo_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = tcfo_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tcfo_pkg::ST_IDLE;
      pos_head_r  <= '0;
      neg_head_r  <= '0;
      pos_count_r <= '0;
      neg_count_r <= '0;
      stamp_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_head_r  <= pos_head_nxt;
      neg_head_r  <= neg_head_nxt;
      pos_count_r <= pos_count_nxt;
      neg_count_r <= neg_count_nxt;
      stamp_r     <= stamp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_ident_r  <= out_ident_nxt;
    if (accept) begin
      pick_r <= in_pick;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_ident_out = out_ident_r;

endmodule

// ===== hdl/tcfo_checker.sv =====
// Port-level checker for the two-class FIFO, bound to the top level.
`include "two_class_fifo_oldest_first_macros.svh"

module tcfo_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic                             in_cmd,
  input logic signed [tcfo_pkg::ID_BITS-1:0] in_ident,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic [1:0]                       out_status,
  input logic signed [tcfo_pkg::ID_BITS-1:0] out_ident_out
);

  logic in_take;
  logic out_fail;
  logic out_ok;
  assign in_take  = in_valid && !in_stall;
  assign out_fail = out_valid && (out_status != tcfo_pkg::STATUS_OK);
  assign out_ok   = out_valid && (out_status == tcfo_pkg::STATUS_OK);

  // A result that is not taken stays offered.
  `TCFO_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
  // Failed requests carry no identifier; served ones always carry a non-zero one.
  `TCFO_ASSERT_NOW(a_fail_zero, clk, rst_n, out_fail, out_ident_out == '0)
  `TCFO_ASSERT_NOW(a_ok_nonzero, clk, rst_n, out_ok, out_ident_out != '0)
  // A zero identifier on enqueue is ignored and produces no result.
  `TCFO_ASSERT_NEXT(a_zero_ignored, clk, rst_n, in_take && (in_cmd == tcfo_pkg::CMD_ENQ) && (in_ident == '0), !out_valid)
  // A dequeue holds off the next request while the queue heads are read.
  `TCFO_ASSERT_NEXT(a_deq_busy, clk, rst_n, in_take && (in_cmd == tcfo_pkg::CMD_DEQ), in_stall)

endmodule

bind two_class_fifo_oldest_first tcfo_checker u_tcfo_checker (.*);

// ===== tb/sv/two_class_fifo_oldest_first_tb.sv =====
// Self-checking testbench for the two-class FIFO with oldest-first service.
`timescale 1ns / 100ps

module two_class_fifo_oldest_first_tb;

  typedef struct {
    logic                                 pause;
    logic                                 cmd;
    logic [1:0]                           pick;
    logic signed [tcfo_pkg::ID_BITS-1:0]  ident;
  } request_t;

  typedef struct {
    logic [1:0]                           status;
    logic signed [tcfo_pkg::ID_BITS-1:0]  ident;
  } answer_t;

  typedef struct {
    logic signed [tcfo_pkg::ID_BITS-1:0]  ident;
    logic [tcfo_pkg::STAMP_BITS-1:0]      stamp;
  } slot_t;

  logic                                 clk = 1'b0;
  logic                                 rst_n = 1'b0;
  logic                                 in_valid = 1'b0;
  logic                                 in_stall;
  logic                                 in_cmd = tcfo_pkg::CMD_ENQ;
  logic [1:0]                           in_pick = tcfo_pkg::PICK_OLDEST;
  logic signed [tcfo_pkg::ID_BITS-1:0]  in_ident = '0;
  logic                                 out_valid;
  logic                                 out_stall = 1'b0;
  logic [1:0]                           out_status;
  logic signed [tcfo_pkg::ID_BITS-1:0]  out_ident_out;

  request_t                             request_backlog[$];
  answer_t                              due_answers[$];
  slot_t                                pos_line[$];
  slot_t                                neg_line[$];
  logic [tcfo_pkg::STAMP_BITS-1:0]      stamp_now = '0;

  logic                                 req_taken = 1'b0;
  logic                                 quiet_stretch = 1'b0;
  int                                   taken_total = 0;
  int                                   errors = 0;
  int                                   n_removed = 0;
  int                                   n_empty = 0;
  int                                   n_full = 0;
  int                                   n_oldest = 0;
  int                                   n_checked = 0;

  two_class_fifo_oldest_first dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cmd       (in_cmd),
    .in_pick      (in_pick),
    .in_ident     (in_ident),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_status   (out_status),
    .out_ident_out(out_ident_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Works out the answer to one accepted request and moves the shadow queues on.
  task automatic serve_request(input request_t r);
    answer_t                         ans;
    slot_t                           s;
    logic [tcfo_pkg::STAMP_BITS-1:0] gap;
    logic                            take_pos;
    logic                            take_neg;
    take_pos = 1'b0;
    take_neg = 1'b0;
    ans.ident = '0;
    if (r.cmd == tcfo_pkg::CMD_ENQ) begin
      if (r.ident == 0) return;
      s.ident = r.ident;
      s.stamp = stamp_now;
      if (r.ident[tcfo_pkg::ID_BITS-1] ? neg_line.size() >= tcfo_pkg::QUEUE_DEPTH
                                       : pos_line.size() >= tcfo_pkg::QUEUE_DEPTH) begin
        ans.status = tcfo_pkg::STATUS_FULL;
        due_answers.push_back(ans);
        n_full++;
        return;
      end
      if (r.ident[tcfo_pkg::ID_BITS-1]) neg_line.push_back(s);
      else pos_line.push_back(s);
      stamp_now++;
      return;
    end
    case (r.pick)
      tcfo_pkg::PICK_POS: take_pos = pos_line.size() != 0;
      tcfo_pkg::PICK_NEG: take_neg = neg_line.size() != 0;
      tcfo_pkg::PICK_OLDEST: begin
        if (pos_line.size() != 0 && neg_line.size() != 0) begin
          // The stamps wrap, so age is read from the sign of the difference.
          gap = pos_line[0].stamp - neg_line[0].stamp;
          take_pos = gap[tcfo_pkg::STAMP_BITS-1];
          take_neg = !gap[tcfo_pkg::STAMP_BITS-1];
          n_oldest++;
        end else begin
          take_pos = pos_line.size() != 0;
          take_neg = neg_line.size() != 0;
        end
      end
      default: ;
    endcase
    if (take_pos) begin
      s = pos_line.pop_front();
      ans.ident = s.ident;
    end else if (take_neg) begin
      s = neg_line.pop_front();
      ans.ident = s.ident;
    end
    ans.status = (take_pos || take_neg) ? tcfo_pkg::STATUS_OK : tcfo_pkg::STATUS_EMPTY;
    if (take_pos || take_neg) n_removed++;
    else n_empty++;
    due_answers.push_back(ans);
  endtask

  // Request driver: the payload is held until the block takes it.
  always @(negedge clk) begin : request_driver
    request_t nxt;
    if (rst_n && (!in_valid || req_taken)) begin
      if (request_backlog.size() != 0 && request_backlog[0].pause) begin
        if (due_answers.size() == 0) void'(request_backlog.pop_front());
        in_valid <= 1'b0;
      end else if (request_backlog.size() != 0 &&
                   (quiet_stretch || $urandom_range(99) >= 8)) begin
        nxt = request_backlog.pop_front();
        in_valid <= 1'b1;
        in_cmd   <= nxt.cmd;
        in_pick  <= nxt.pick;
        in_ident <= nxt.ident;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= !quiet_stretch && $urandom_range(99) < 8;
  end

  // Monitor: checks each result taken, then predicts from each request taken.
  always @(posedge clk) begin : result_monitor
    answer_t  want;
    request_t got;
    if (rst_n && out_valid && !out_stall) begin
      n_checked++;
      if (due_answers.size() == 0) begin
        $error("result with nothing outstanding: status %0d, ident_out %0d",
               out_status, out_ident_out);
        errors++;
      end else begin
        want = due_answers.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_status);
          errors++;
        end
        if (out_ident_out !== want.ident) begin
          $error("ident_out: expected %0d, actual %0d", want.ident, out_ident_out);
          errors++;
        end
      end
    end
    if (rst_n && in_valid && !in_stall) begin
      got.pause = 1'b0;
      got.cmd   = in_cmd;
      got.pick  = in_pick;
      got.ident = in_ident;
      serve_request(got);
      taken_total++;
    end
    req_taken     <= rst_n && in_valid && !in_stall;
    quiet_stretch <= taken_total >= 200 && taken_total < 330;
  end

  function automatic logic signed [tcfo_pkg::ID_BITS-1:0] class_ident(input logic neg);
    logic [tcfo_pkg::ID_BITS-1:0] v;
    v = $urandom;
    case ($urandom_range(15))
      0: v = neg ? {1'b1, {(tcfo_pkg::ID_BITS-1){1'b0}}}
                 : {1'b0, {(tcfo_pkg::ID_BITS-1){1'b1}}};
      1: v = neg ? '1 : tcfo_pkg::ID_BITS'(1);
      default: v[tcfo_pkg::ID_BITS-1] = neg;
    endcase
    if (v == 0) v = tcfo_pkg::ID_BITS'(1);
    return v;
  endfunction

  task automatic add_request(input logic cmd, input logic [1:0] pick,
                             input logic signed [tcfo_pkg::ID_BITS-1:0] ident);
    request_t r;
    r.pause = 1'b0;
    r.cmd   = cmd;
    r.pick  = pick;
    r.ident = ident;
    request_backlog.push_back(r);
  endtask

  task automatic add_pause();
    request_t r;
    r.pause = 1'b1;
    r.cmd   = tcfo_pkg::CMD_ENQ;
    r.pick  = tcfo_pkg::PICK_OLDEST;
    r.ident = '0;
    request_backlog.push_back(r);
  endtask

  task automatic add_random(input int enq_pct);
    logic [1:0]                          pk;
    logic signed [tcfo_pkg::ID_BITS-1:0] id;
    pk = ($urandom_range(19) == 0) ? 2'd3 : 2'($urandom_range(2));
    if ($urandom_range(99) < enq_pct) begin
      id = ($urandom_range(99) < 6) ? '0 : class_ident(1'($urandom_range(1)));
      add_request(tcfo_pkg::CMD_ENQ, pk, id);
    end else begin
      add_request(tcfo_pkg::CMD_DEQ, pk, $urandom);
    end
  endtask

  initial begin
    // Empty answers from every class, including the unused pick value.
    add_request(tcfo_pkg::CMD_DEQ, tcfo_pkg::PICK_OLDEST, '0);
    add_request(tcfo_pkg::CMD_DEQ, tcfo_pkg::PICK_POS, '0);
    add_request(tcfo_pkg::CMD_DEQ, tcfo_pkg::PICK_NEG, '1);
    add_request(tcfo_pkg::CMD_DEQ, 2'd3, '0);
    add_request(tcfo_pkg::CMD_ENQ, 2'd3, '0);
    add_request(tcfo_pkg::CMD_ENQ, tcfo_pkg::PICK_OLDEST, 32'sh7fffffff);
    add_request(tcfo_pkg::CMD_ENQ, tcfo_pkg::PICK_OLDEST, 32'sh80000000);
    add_request(tcfo_pkg::CMD_ENQ, tcfo_pkg::PICK_POS, 32'sd1);
    add_request(tcfo_pkg::CMD_ENQ, tcfo_pkg::PICK_NEG, -32'sd1);
    add_request(tcfo_pkg::CMD_DEQ, 2'd3, '0);
    add_request(tcfo_pkg::CMD_DEQ, tcfo_pkg::PICK_OLDEST, '0);
    add_request(tcfo_pkg::CMD_DEQ, tcfo_pkg::PICK_OLDEST, '0);
    add_request(tcfo_pkg::CMD_DEQ, tcfo_pkg::PICK_NEG, '0);
    add_request(tcfo_pkg::CMD_DEQ, tcfo_pkg::PICK_OLDEST, '0);
    add_request(tcfo_pkg::CMD_ENQ, tcfo_pkg::PICK_OLDEST, -32'sd5);
    add_request(tcfo_pkg::CMD_DEQ, tcfo_pkg::PICK_POS, '0);
    add_request(tcfo_pkg::CMD_DEQ, tcfo_pkg::PICK_OLDEST, '0);
    add_request(tcfo_pkg::CMD_ENQ, tcfo_pkg::PICK_OLDEST, '0);
    add_request(tcfo_pkg::CMD_DEQ, tcfo_pkg::PICK_NEG, '0);
    // Here the negative head is the older one.
    add_request(tcfo_pkg::CMD_ENQ, tcfo_pkg::PICK_OLDEST, -32'sd7);
    add_request(tcfo_pkg::CMD_ENQ, tcfo_pkg::PICK_OLDEST, 32'sd9);
    add_request(tcfo_pkg::CMD_DEQ, tcfo_pkg::PICK_OLDEST, '0);
    add_request(tcfo_pkg::CMD_DEQ, tcfo_pkg::PICK_OLDEST, '0);
    add_pause();

    repeat (20) add_random(55);
    add_pause();

    // Fill the positive queue past its depth, whatever it already holds.
    repeat (tcfo_pkg::QUEUE_DEPTH + 4)
      add_request(tcfo_pkg::CMD_ENQ, 2'($urandom_range(3)), class_ident(1'b0));

    // Fill the negative queue while oldest-first requests drain the positive one.
    for (int i = 0; i < tcfo_pkg::QUEUE_DEPTH + 8; i++) begin
      add_request(tcfo_pkg::CMD_ENQ, 2'($urandom_range(3)), class_ident(1'b1));
      if (i % 4 == 3) add_request(tcfo_pkg::CMD_DEQ, tcfo_pkg::PICK_OLDEST, $urandom);
    end
    add_pause();

    repeat (20) add_random(30);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (request_backlog.size() != 0 || in_valid) @(posedge clk);
    while (due_answers.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("requests taken %0d, results checked %0d", taken_total, n_checked);
    $display("removals %0d (%0d by age), empty answers %0d, full-queue drops %0d",
             n_removed, n_oldest, n_empty, n_full);
    if (errors == 0) begin
      $display("two_class_fifo_oldest_first_tb: done, clean");
    end else begin
      $display("two_class_fifo_oldest_first_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("two_class_fifo_oldest_first_tb: done, errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/tcfo_pkg.sv
hdl/two_class_fifo_oldest_first.sv
hdl/tcfo_checker.sv
tb/sv/two_class_fifo_oldest_first_tb.sv
